@@ rtl/core/jsu_pkg.sv @@
// shared types, character codes and helpers for the json string unescaper
`default_nettype none

package jsu_pkg;

    localparam int MAX_RES = 6;
    localparam int CNT_W   = $clog2(MAX_RES + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [7:0] UTF_CONT  = 8'h80;
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;

    // bytes produced by one input transfer, lowest index goes out first
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        count;
        logic                    last;
    } res_t;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] v;
        v = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/jsu_decode.sv @@
// escape state and single-pass decode of one input byte into up to six result bytes
`default_nettype none

module jsu_decode
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output res_t            res
);

    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_ESC  = 6'b000010,
        PH_U0   = 6'b000100,
        PH_U1   = 6'b001000,
        PH_U2   = 6'b010000,
        PH_U3   = 6'b100000
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [11:0]      code_reg, code_next;
    logic [2:0][7:0]  held_reg, held_next;

    logic [4:0]       hex;
    logic [15:0]      cp;

    function automatic logic [1:0] held_count(input phase_t p);
        logic [1:0] c;
        case (p)
            PH_U1:   c = 2'd1;
            PH_U2:   c = 2'd2;
            PH_U3:   c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    function automatic logic in_hex(input phase_t p);
        return (p == PH_U0) || (p == PH_U1) || (p == PH_U2) || (p == PH_U3);
    endfunction

    assign hex = hex_value(in_byte);
    assign cp  = {code_reg, hex[3:0]};

    always_comb
    begin
        logic [MAX_RES-1:0][7:0] bytes;
        logic [CNT_W-1:0]        n;
        logic [1:0]              hc;

        bytes      = '0;
        n          = '0;
        phase_next = phase_reg;
        code_next  = code_reg;
        held_next  = held_reg;
        hc         = held_count(phase_reg);

        case (phase_reg)
            PH_ESC:
            begin
                phase_next = PH_IDLE;
                if (in_byte == CH_N) begin
                    bytes[n] = CH_LF; n = n + 1'b1;
                end
                else if (in_byte == CH_R) begin
                    bytes[n] = CH_CR; n = n + 1'b1;
                end
                else if (in_byte == CH_QUOTE || in_byte == CH_BSLASH) begin
                    bytes[n] = in_byte; n = n + 1'b1;
                end
                else if (in_byte == CH_U) begin
                    phase_next = PH_U0;
                    code_next  = '0;
                end
                else begin
                    bytes[n] = CH_BSLASH; n = n + 1'b1;
                    bytes[n] = in_byte;   n = n + 1'b1;
                end
            end
            PH_U0, PH_U1, PH_U2, PH_U3:
            begin
                if (hex[4]) begin
                    // replay the open escape, then the byte as plain input
                    bytes[n] = CH_BSLASH; n = n + 1'b1;
                    bytes[n] = CH_U;      n = n + 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        if (2'(k) < hc) begin
                            bytes[n] = held_reg[k]; n = n + 1'b1;
                        end
                    end
                    if (in_byte == CH_BSLASH) begin
                        phase_next = PH_ESC;
                    end
                    else begin
                        bytes[n]   = in_byte; n = n + 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                else if (phase_reg == PH_U3) begin
                    phase_next = PH_IDLE;
                    if (cp[15:7] == '0) begin
                        bytes[n] = {1'b0, cp[6:0]}; n = n + 1'b1;
                    end
                    else if (cp[15:11] == '0) begin
                        bytes[n] = UTF_LEAD2 | {3'b000, cp[10:6]}; n = n + 1'b1;
                        bytes[n] = UTF_CONT  | {2'b00, cp[5:0]};   n = n + 1'b1;
                    end
                    else begin
                        bytes[n] = UTF_LEAD3 | {4'b0000, cp[15:12]}; n = n + 1'b1;
                        bytes[n] = UTF_CONT  | {2'b00, cp[11:6]};    n = n + 1'b1;
                        bytes[n] = UTF_CONT  | {2'b00, cp[5:0]};     n = n + 1'b1;
                    end
                end
                else begin
                    held_next[hc] = in_byte;
                    code_next     = {code_reg[7:0], hex[3:0]};
                    case (phase_reg)
                        PH_U0:   phase_next = PH_U1;
                        PH_U1:   phase_next = PH_U2;
                        default: phase_next = PH_U3;
                    endcase
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (in_byte == CH_BSLASH) begin
                    phase_next = PH_ESC;
                end
                else begin
                    bytes[n] = in_byte; n = n + 1'b1;
                end
            end
        endcase

        // end of string: flush whatever escape is still open
        if (in_last && phase_next != PH_IDLE) begin
            bytes[n] = CH_BSLASH; n = n + 1'b1;
            if (in_hex(phase_next)) begin
                bytes[n] = CH_U; n = n + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (2'(k) < held_count(phase_next)) begin
                        bytes[n] = held_next[k]; n = n + 1'b1;
                    end
                end
            end
            phase_next = PH_IDLE;
        end

        res.bytes = bytes;
        res.count = n;
        res.last  = in_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_IDLE;
            code_reg  <= '0;
        end
        else if (accept) begin
            phase_reg <= phase_next;
            code_reg  <= code_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/jsu_outbuf.sv @@
// result register that shifts out one byte per transfer
`default_nettype none

module jsu_outbuf
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire res_t       res,
    output logic            free,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    logic [MAX_RES-1:0][7:0] buf_reg, buf_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    last_reg, last_next;
    logic                    take;

    assign out_valid = (cnt_reg != '0);
    assign take      = out_valid && !out_stall;
    // room for a new result once the last pending byte leaves
    assign free      = (cnt_reg == '0) || (cnt_reg == CNT_W'(1) && !out_stall);
    assign out_byte  = buf_reg[0];
    assign out_last  = last_reg && (cnt_reg == CNT_W'(1));

    always_comb
    begin
        buf_next  = buf_reg;
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (load && res.count != '0) begin
            buf_next  = res.bytes;
            cnt_next  = res.count;
            last_next = res.last;
        end
        else if (take) begin
            buf_next = buf_reg >> 8;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            last_reg <= 1'b0;
        end
        else begin
            cnt_reg  <= cnt_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/json_string_unescape_top.sv @@
// top level of the streaming json string unescaper
`default_nettype none

// Decodes a JSON escaped byte stream: \n \r \" \\ become single bytes and \uXXXX
// becomes one to three bytes of UTF-8 (surrogates encoded alone). Malformed or
// truncated escapes are passed through literally; in_last closes the string and
// flushes any open escape, and out_last marks the final byte it produces.
// Each input transfer is decoded combinationally into a six-byte result register,
// which drains one byte per cycle on the output while out_stall is low. A byte that
// yields at most one output byte is taken every cycle while out_stall is low; a byte
// that yields more stalls the input until its last output byte leaves, set by the
// single output byte lane. First output byte appears in the cycle after the input
// transfer.
module json_string_unescape_top
    import jsu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_last
);

    res_t res;
    logic free;
    logic accept;

    assign in_stall = !free;
    assign accept   = in_valid && free;

    jsu_decode u_decode (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .in_byte (in_byte),
        .in_last (in_last),
        .res     (res)
    );

    jsu_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last)
    );

    // an empty result register never holds off the input
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // a transfer that makes bytes must show them next cycle
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.count != '0) |=> out_valid)
        else $error("result bytes lost after input transfer");

    // never more bytes than the result register holds
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> (res.count <= CNT_W'(MAX_RES)))
        else $error("result count exceeds buffer");

endmodule

`default_nettype wire
